FILE: rtl/svg_pkg.sv
`default_nettype none
package svg_pkg;

  localparam int MAX_COUNT = 63;
  localparam int EXT       = 8;   // extra fraction bits carried inside
  localparam int CW        = 28;  // internal coordinate width
  localparam int TURN_BITS = 24;
  localparam int QUAD_BITS = 22;
  localparam int DIV_NW    = 48;
  localparam int DIV_DW    = 24;
  localparam int MUL_BW    = 18;
  localparam int PROD_W    = CW + MUL_BW;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  localparam logic [2:0] OP_CIRCLE = 3'd0;
  localparam logic [2:0] OP_RECT   = 3'd1;
  localparam logic [2:0] OP_TRI    = 3'd2;
  localparam logic [2:0] OP_STAR   = 3'd3;
  localparam logic [2:0] OP_CROSS  = 3'd4;
  localparam logic [2:0] OP_ARROW  = 3'd5;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_RADIUS = 3'd1;
  localparam logic [2:0] ERR_DIR    = 3'd2;
  localparam logic [2:0] ERR_TIPS   = 3'd3;
  localparam logic [2:0] ERR_THICK  = 3'd4;

  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_REPEAT   = 2'd2;

  localparam logic signed [MUL_BW-1:0] GAIN_Q16  = 18'sd39797;
  localparam logic signed [MUL_BW-1:0] SQRT3_Q16 = 18'sd113512;
  localparam logic signed [MUL_BW-1:0] GOLD_Q16  = 18'sd40503;

  localparam logic signed [CW-EXT:0] SAT_HI = 32767;
  localparam logic signed [CW-EXT:0] SAT_LO = -32768;

  // atan(2^-k) in 2^-24 turn
  function automatic logic signed [24:0] atan_turn(input logic [3:0] k);
    logic signed [24:0] v;
    unique case (k)
      4'd0:  v = 25'sd2097152;
      4'd1:  v = 25'sd1238021;
      4'd2:  v = 25'sd654136;
      4'd3:  v = 25'sd332050;
      4'd4:  v = 25'sd166669;
      4'd5:  v = 25'sd83416;
      4'd6:  v = 25'sd41718;
      4'd7:  v = 25'sd20860;
      4'd8:  v = 25'sd10430;
      4'd9:  v = 25'sd5215;
      4'd10: v = 25'sd2608;
      4'd11: v = 25'sd1304;
      4'd12: v = 25'sd652;
      4'd13: v = 25'sd326;
      4'd14: v = 25'sd163;
      4'd15: v = 25'sd81;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  // round half up to a 16-bit integer (Q16.0), add offset, saturate
  function automatic logic signed [15:0] to_out(input coord_t v,
                                                input logic signed [15:0] off);
    coord_t r;
    logic signed [CW-EXT-1:0] t;
    logic signed [CW-EXT:0] s;
    logic signed [15:0] o;
    r = v + coord_t'(1 << (EXT - 1));
    t = r[CW-1:EXT];
    s = {t[CW-EXT-1], t} + {{(CW-EXT-15){off[15]}}, off};
    if (s > SAT_HI) o = 16'sh7fff;
    else if (s < SAT_LO) o = -16'sh8000;
    else o = s[15:0];
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/svg_if.sv
`default_nettype none
interface svg_shape_if;
  logic valid;
  logic ready;
  logic [2:0] operation;
  logic signed [15:0] size;
  logic signed [15:0] height;
  logic [15:0] thickness;
  logic [5:0] count;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  modport source(output valid, operation, size, height, thickness, count, dir_x, dir_y,
                 input ready);
  modport sink(input valid, operation, size, height, thickness, count, dir_x, dir_y,
               output ready);
endinterface

interface svg_vertex_if;
  logic valid;
  logic ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic last;
  logic [2:0] error;
  modport source(output valid, vertex_x, vertex_y, last, error, input ready);
  modport sink(input valid, vertex_x, vertex_y, last, error, output ready);
endinterface

interface svg_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/svg_div.sv
`default_nettype none
module svg_div import svg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              busy_o,
  output logic [DIV_NW-1:0] quo_o,
  output logic [DIV_DW-1:0] rem_o
);
  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_DW:0]   sh, diff;

  // restoring division, one quotient bit per cycle
  assign sh   = {rem_q, quo_q[DIV_NW-1]};
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_NW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DIV_DW]) begin
        rem_q <= diff[DIV_DW-1:0];
        quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_q <= sh[DIV_DW-1:0];
        quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

FILE: rtl/shape_vertex_generator.sv
`default_nettype none
// Shape vertex generator: takes one shape request per item and returns its
// outline vertices, one item per vertex, offset and saturated to Q16.0; the
// final item of a shape carries last, a bad request gives one error item.
// The block takes a new request only when the previous one is finished.
// Rectangle, cross and arrow go through setup states (none for a rectangle,
// LM1 and LM2 for a cross, LM1 to LM5 for an arrow), then give one vertex
// per cycle while the output is not stalled. Circle, triangle and star
// vertices come from a shared CORDIC rotator: each vertex takes a setup
// step, 2 gain multiplies and 16 rotation steps (both skipped on a quarter
// turn) and an output step, after a setup of one division for a circle and
// of a square root and three divisions (x, y, angle step) in one shared
// bit-serial divider for a triangle or star. Backpressure stalls the output.
module shape_vertex_generator import svg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  svg_cfg_if.sink      cfg_i,
  svg_shape_if.sink    shp_i,
  svg_vertex_if.source vtx_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FAIL   = 5'd1;
  localparam logic [4:0] S_LIST   = 5'd2;
  localparam logic [4:0] S_LM1    = 5'd3;
  localparam logic [4:0] S_LM2    = 5'd4;
  localparam logic [4:0] S_LM3    = 5'd5;
  localparam logic [4:0] S_LM4    = 5'd6;
  localparam logic [4:0] S_LM5    = 5'd7;
  localparam logic [4:0] S_SQ_X   = 5'd8;
  localparam logic [4:0] S_SQ_Y   = 5'd9;
  localparam logic [4:0] S_SQ_SUM = 5'd10;
  localparam logic [4:0] S_ROOT   = 5'd11;
  localparam logic [4:0] S_NUMX   = 5'd12;
  localparam logic [4:0] S_DIVX   = 5'd13;
  localparam logic [4:0] S_DIVX_W = 5'd14;
  localparam logic [4:0] S_NUMY   = 5'd15;
  localparam logic [4:0] S_DIVY   = 5'd16;
  localparam logic [4:0] S_DIVY_W = 5'd17;
  localparam logic [4:0] S_ANG    = 5'd18;
  localparam logic [4:0] S_ANG_W  = 5'd19;
  localparam logic [4:0] S_VTX    = 5'd20;
  localparam logic [4:0] S_GX     = 5'd21;
  localparam logic [4:0] S_GY     = 5'd22;
  localparam logic [4:0] S_GW     = 5'd23;
  localparam logic [4:0] S_ROT    = 5'd24;
  localparam logic [4:0] S_EMIT   = 5'd25;

  localparam logic [5:0] MAX_N   = 6'(MAX_COUNT);
  localparam logic [4:0] MAX_TIP = 5'(MAX_COUNT / 2);

  logic [4:0] state_q, state_d;

  logic signed [15:0] off_x_q, off_y_q;
  logic               repeat_q;

  logic [2:0]         op_q, err_code_q;
  logic signed [15:0] size_q, dx_q, dy_q;
  logic [5:0]         steps_q, i_q;
  logic               alt_q, rep_q, neg_q;
  logic [3:0]         idx_q, k_q;
  coord_t             x_q, y_q, rx_q, ry_q, pa_q, pb_q, pc_q, pd_q;
  logic [31:0]        l2_q;
  logic [DIV_NW-1:0]  sq_v_q, sq_res_q, sq_bit_q;
  logic [24:0]        ang_q, q0_q;
  logic [6:0]         ang_r_q;
  logic [5:0]         r0_q;
  logic signed [24:0] z_q;
  logic [1:0]         quad_q;
  logic signed [PROD_W-1:0] prod_q;

  logic               ov_q, olast_q;
  logic signed [15:0] ox_q, oy_q;
  logic [2:0]         oerr_q;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q  <= '0;
      off_y_q  <= '0;
      repeat_q <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_OFFSET_X: off_x_q  <= cfg_i.data;
        CFG_OFFSET_Y: off_y_q  <= cfg_i.data;
        CFG_REPEAT:   repeat_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // ---------------- shared multiplier ----------------
  coord_t                   mul_a;
  logic signed [MUL_BW-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ_X: begin mul_a = coord_t'(dx_q); mul_b = MUL_BW'(dx_q); end
      S_SQ_Y: begin mul_a = coord_t'(dy_q); mul_b = MUL_BW'(dy_q); end
      S_NUMX: begin mul_a = coord_t'(dx_q); mul_b = MUL_BW'(size_q); end
      S_NUMY: begin mul_a = coord_t'(dy_q); mul_b = MUL_BW'(size_q); end
      S_GX:   begin mul_a = x_q; mul_b = GAIN_Q16; end
      S_GY:   begin mul_a = y_q; mul_b = GAIN_Q16; end
      S_LM1:  begin mul_a = coord_t'(size_q); mul_b = {2'b00, pd_q[15:0]}; end
      S_LM3:  begin mul_a = pb_q; mul_b = SQRT3_Q16; end
      S_LM4:  begin mul_a = pb_q; mul_b = GOLD_Q16; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) prod_q <= mul_a * mul_b;

  // ---------------- shared divider ----------------
  logic              div_start, div_busy;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den, div_rem;
  logic [30:0]       num_mag;

  assign num_mag = prod_q[31] ? 31'(-prod_q[31:0]) : prod_q[30:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = {num_mag, 16'b0} + DIV_NW'(sq_res_q[DIV_DW-1:1]);
    div_den   = sq_res_q[DIV_DW-1:0];
    unique case (state_q)
      S_DIVX, S_DIVY: div_start = 1'b1;
      S_ANG: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(1) << TURN_BITS;
        div_den   = DIV_DW'(steps_q);
      end
      default: ;
    endcase
  end

  svg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // ---------------- request decode ----------------
  logic       size_pos, dir_zero, thick_bad;
  logic [2:0] acc_code;
  logic [4:0] acc_next;
  logic [5:0] circ_n;
  logic [4:0] tips;

  assign size_pos  = !shp_i.size[15] && (shp_i.size != 16'sd0);
  assign dir_zero  = (shp_i.dir_x == 16'sd0) && (shp_i.dir_y == 16'sd0);
  assign thick_bad = (shp_i.thickness == 16'd0) || (shp_i.thickness >= 16'd16384);
  assign circ_n    = (shp_i.count > MAX_N) ? MAX_N : shp_i.count;
  assign tips      = (shp_i.count > 6'(MAX_TIP)) ? MAX_TIP : shp_i.count[4:0];

  always_comb begin
    acc_code = ERR_NONE;
    acc_next = S_IDLE;
    unique case (shp_i.operation)
      OP_CIRCLE: begin
        if (!size_pos) acc_code = ERR_RADIUS;
        else acc_next = S_ANG;
      end
      OP_RECT: acc_next = S_LIST;
      OP_TRI, OP_STAR: begin
        if (dir_zero) acc_code = ERR_DIR;
        else if (!size_pos) acc_code = ERR_RADIUS;
        else if (shp_i.operation == OP_STAR && shp_i.count < 6'd4) acc_code = ERR_TIPS;
        else acc_next = S_SQ_X;
      end
      OP_CROSS: begin
        if (thick_bad) acc_code = ERR_THICK;
        else acc_next = S_LM1;
      end
      OP_ARROW: acc_next = S_LM1;
      default: ;
    endcase
    if (acc_code != ERR_NONE) acc_next = S_FAIL;
  end

  // ---------------- rotation step and vertex helpers ----------------
  coord_t      rot_dx, rot_dy;
  logic [23:0] phase;
  logic [6:0]  ang_r_sum;
  logic        vtx_done, emit_last, list_last, out_free, out_load;
  logic [3:0]  list_base, list_eidx;

  assign rot_dx    = y_q >>> k_q;
  assign rot_dy    = x_q >>> k_q;
  assign phase     = ~ang_q[23:0] + 24'd1;
  assign ang_r_sum = ang_r_q + 7'(r0_q);
  assign vtx_done  = (i_q == steps_q);
  assign emit_last = rep_q || (!repeat_q && (i_q == 6'(steps_q - 6'd1)));

  always_comb begin
    unique case (op_q)
      OP_CROSS: list_base = 4'd12;
      OP_ARROW: list_base = 4'd7;
      default:  list_base = 4'd4;
    endcase
  end
  assign list_eidx = (idx_q == list_base) ? 4'd0 : idx_q;
  assign list_last = (idx_q == 4'(list_base - {3'b000, !repeat_q}));

  function automatic point_t quad_rot(input coord_t x, input coord_t y,
                                      input logic [1:0] q);
    point_t p;
    unique case (q)
      2'd0: begin p.x = x;  p.y = y;  end
      2'd1: begin p.x = -y; p.y = x;  end
      2'd2: begin p.x = -x; p.y = -y; end
      2'd3: begin p.x = y;  p.y = -x; end
      default: begin p.x = x; p.y = y; end
    endcase
    return p;
  endfunction

  // a: half width, b: half height / thickness, c: arrow neck x, d: arrow y2
  function automatic point_t list_vertex(input logic [2:0] op, input logic [3:0] n,
                                         input coord_t a, input coord_t b,
                                         input coord_t c, input coord_t d);
    point_t p;
    p.x = '0;
    p.y = '0;
    case (op)
      OP_CROSS: begin
        case (n)
          4'd0:  begin p.x = -a; p.y = -b; end
          4'd1:  begin p.x = -a; p.y = b;  end
          4'd2:  begin p.x = -b; p.y = b;  end
          4'd3:  begin p.x = -b; p.y = a;  end
          4'd4:  begin p.x = b;  p.y = a;  end
          4'd5:  begin p.x = b;  p.y = b;  end
          4'd6:  begin p.x = a;  p.y = b;  end
          4'd7:  begin p.x = a;  p.y = -b; end
          4'd8:  begin p.x = b;  p.y = -b; end
          4'd9:  begin p.x = b;  p.y = -a; end
          4'd10: begin p.x = -b; p.y = -a; end
          default: begin p.x = -b; p.y = -b; end
        endcase
      end
      OP_ARROW: begin
        case (n)
          4'd0: begin p.x = -a; p.y = -d; end
          4'd1: begin p.x = -a; p.y = d;  end
          4'd2: begin p.x = c;  p.y = d;  end
          4'd3: begin p.x = c;  p.y = b;  end
          4'd4: begin p.x = a;  p.y = '0; end
          4'd5: begin p.x = c;  p.y = -b; end
          default: begin p.x = c; p.y = -d; end
        endcase
      end
      default: begin
        case (n)
          4'd0: begin p.x = -a; p.y = -b; end
          4'd1: begin p.x = -a; p.y = b;  end
          4'd2: begin p.x = a;  p.y = b;  end
          default: begin p.x = a; p.y = -b; end
        endcase
      end
    endcase
    return p;
  endfunction

  // ---------------- output register ----------------
  point_t             emit_pt, list_pt;
  logic signed [15:0] ox_d, oy_d;
  logic               olast_d;
  logic [2:0]         oerr_d;

  assign out_free = !ov_q || vtx_o.ready;
  assign emit_pt  = quad_rot(x_q, y_q, quad_q);
  assign list_pt  = list_vertex(op_q, list_eidx, pa_q, pb_q, pc_q, pd_q);

  always_comb begin
    out_load = 1'b0;
    ox_d     = to_out(emit_pt.x, off_x_q);
    oy_d     = to_out(emit_pt.y, off_y_q);
    olast_d  = emit_last;
    oerr_d   = ERR_NONE;
    unique case (state_q)
      S_EMIT: out_load = out_free;
      S_LIST: begin
        out_load = out_free;
        ox_d     = to_out(list_pt.x, off_x_q);
        oy_d     = to_out(list_pt.y, off_y_q);
        olast_d  = list_last;
      end
      S_FAIL: begin
        out_load = out_free;
        ox_d     = '0;
        oy_d     = '0;
        olast_d  = 1'b1;
        oerr_d   = err_code_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (out_load) ov_q <= 1'b1;
    else if (vtx_o.ready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      olast_q <= olast_d;
      oerr_q  <= oerr_d;
    end
  end

  assign vtx_o.valid    = ov_q;
  assign vtx_o.vertex_x = ox_q;
  assign vtx_o.vertex_y = oy_q;
  assign vtx_o.last     = olast_q;
  assign vtx_o.error    = oerr_q;

  // ---------------- sequencer ----------------
  assign shp_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (shp_i.valid) state_d = acc_next;
      S_FAIL:   if (out_free) state_d = S_IDLE;
      S_LIST:   if (out_free && list_last) state_d = S_IDLE;
      S_LM1:    state_d = S_LM2;
      S_LM2:    state_d = (op_q == OP_CROSS) ? S_LIST : S_LM3;
      S_LM3:    state_d = S_LM4;
      S_LM4:    state_d = S_LM5;
      S_LM5:    state_d = S_LIST;
      S_SQ_X:   state_d = S_SQ_Y;
      S_SQ_Y:   state_d = S_SQ_SUM;
      S_SQ_SUM: state_d = S_ROOT;
      S_ROOT:   if (sq_bit_q == '0) state_d = S_NUMX;
      S_NUMX:   state_d = S_DIVX;
      S_DIVX:   state_d = S_DIVX_W;
      S_DIVX_W: if (!div_busy) state_d = S_NUMY;
      S_NUMY:   state_d = S_DIVY;
      S_DIVY:   state_d = S_DIVY_W;
      S_DIVY_W: if (!div_busy) state_d = S_ANG;
      S_ANG:    state_d = S_ANG_W;
      S_ANG_W:  if (!div_busy) state_d = S_VTX;
      S_VTX: begin
        if (vtx_done) state_d = repeat_q ? S_EMIT : S_IDLE;
        else if (phase[QUAD_BITS-1:0] != '0) state_d = S_GX;
        else state_d = S_EMIT;
      end
      S_GX:     state_d = S_GY;
      S_GY:     state_d = S_GW;
      S_GW:     state_d = S_ROT;
      S_ROT:    if (k_q == 4'd15) state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = emit_last ? S_IDLE : S_VTX;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  logic [DIV_NW-1:0] sq_try;
  logic [31:0]       l2_sum;
  coord_t            h_rnd;

  assign sq_try = sq_res_q + sq_bit_q;
  assign l2_sum = l2_q + prod_q[31:0];
  assign h_rnd  = coord_t'((prod_q + PROD_W'(32768)) >>> 16);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q       <= shp_i.operation;
        size_q     <= shp_i.size;
        dx_q       <= shp_i.dir_x;
        dy_q       <= shp_i.dir_y;
        err_code_q <= acc_code;
        idx_q      <= '0;
        i_q        <= '0;
        alt_q      <= (shp_i.operation == OP_STAR);
        pa_q       <= coord_t'(shp_i.size) <<< (EXT - 1);
        pb_q       <= coord_t'(shp_i.height) <<< (EXT - 1);
        pd_q       <= coord_t'({1'b0, shp_i.thickness});
        rx_q       <= coord_t'(shp_i.size) <<< EXT;
        ry_q       <= '0;
        if (shp_i.operation == OP_CIRCLE) steps_q <= circ_n;
        else if (shp_i.operation == OP_TRI) steps_q <= 6'd3;
        else steps_q <= {tips, 1'b0};
      end
      S_LIST: if (out_free) idx_q <= idx_q + 4'd1;
      S_LM2:  pb_q <= coord_t'(prod_q >>> (EXT - 1));
      S_LM4:  pc_q <= pa_q - h_rnd;
      S_LM5:  pd_q <= h_rnd;
      S_SQ_Y: l2_q <= prod_q[31:0];
      S_SQ_SUM: begin
        sq_v_q   <= {l2_sum, 16'b0};
        sq_res_q <= '0;
        sq_bit_q <= DIV_NW'(1) << (DIV_NW - 2);
      end
      S_ROOT: begin
        if (sq_bit_q != '0) begin
          if (sq_v_q >= sq_try) begin
            sq_v_q   <= sq_v_q - sq_try;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
      end
      S_DIVX, S_DIVY: neg_q <= prod_q[31];
      S_DIVX_W: if (!div_busy) rx_q <= neg_q ? -coord_t'(div_quo) : coord_t'(div_quo);
      S_DIVY_W: if (!div_busy) ry_q <= neg_q ? -coord_t'(div_quo) : coord_t'(div_quo);
      S_ANG_W: begin
        q0_q    <= div_quo[24:0];
        r0_q    <= div_rem[5:0];
        ang_q   <= '0;
        ang_r_q <= {2'b00, steps_q[5:1]};
      end
      S_VTX: begin
        if (vtx_done) begin
          x_q    <= rx_q;
          y_q    <= ry_q;
          quad_q <= 2'd0;
          rep_q  <= 1'b1;
        end else begin
          x_q    <= (alt_q && i_q[0]) ? (rx_q >>> 1) : rx_q;
          y_q    <= (alt_q && i_q[0]) ? (ry_q >>> 1) : ry_q;
          quad_q <= phase[TURN_BITS-1:QUAD_BITS];
          z_q    <= 25'(phase[QUAD_BITS-1:0]);
          k_q    <= '0;
          rep_q  <= 1'b0;
          // next angle: step of q0 rem r0, carry when remainder wraps
          if (ang_r_sum >= 7'(steps_q)) begin
            ang_r_q <= ang_r_sum - 7'(steps_q);
            ang_q   <= ang_q + q0_q + 25'd1;
          end else begin
            ang_r_q <= ang_r_sum;
            ang_q   <= ang_q + q0_q;
          end
        end
      end
      S_GY: x_q <= prod_q[CW+15:16];
      S_GW: y_q <= prod_q[CW+15:16];
      S_ROT: begin
        if (!z_q[24]) begin
          x_q <= x_q - rot_dx;
          y_q <= y_q + rot_dy;
          z_q <= z_q - atan_turn(k_q);
        end else begin
          x_q <= x_q + rot_dx;
          y_q <= y_q - rot_dy;
          z_q <= z_q + atan_turn(k_q);
        end
        k_q <= k_q + 4'd1;
      end
      S_EMIT: if (out_free) i_q <= i_q + 6'd1;
      default: ;
    endcase
  end

  // ---------------- checks ----------------
  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shp_i.ready |-> !div_busy)
    else $error("divider busy while taking a new item");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && olast_d) |=> (state_q == S_IDLE))
    else $error("sequencer still running after last item");

  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_o.valid && (vtx_o.error != ERR_NONE)) |->
      (vtx_o.last && (vtx_o.vertex_x == 16'sd0) && (vtx_o.vertex_y == 16'sd0)))
    else $error("error item not a lone zero vertex");

endmodule
`default_nettype wire

FILE: tb/sv/tb_shape_vertex_generator.sv
`timescale 1ns / 1ps
module tb_shape_vertex_generator;
  import svg_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] size;
    logic signed [15:0] height;
    logic [15:0]        thick;
    logic [5:0]         count;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } shape_req_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic [2:0]         err;
  } vertex_t;

  typedef struct {
    shape_req_t req;
    bit         typed;
    logic [2:0] err;
  } directed_row_t;

  localparam longint TURN = 64'd16777216;
  localparam int     IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  svg_cfg_if    cfg ();
  svg_shape_if  shp ();
  svg_vertex_if vtx ();

  shape_vertex_generator i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .shp_i (shp),
    .vtx_o (vtx)
  );

  vertex_t vertex_q[$];
  longint  offset_x, offset_y;
  bit      close_outline;
  int      mismatches, shapes_sent, vertices_seen, idle_cycles;

  // ---------------- predictor ----------------
  function automatic logic signed [15:0] sat_coord(longint ext, longint off);
    longint v;
    v = ((ext + 128) >>> 8) + off;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void add_vertex(longint x, longint y);
    vertex_t v;
    v.x = sat_coord(x, offset_x);
    v.y = sat_coord(y, offset_y);
    v.last = 1'b0;
    v.err = ERR_NONE;
    vertex_q.push_back(v);
  endfunction

  function automatic void add_error(logic [2:0] code);
    vertex_t v;
    v.x = '0;
    v.y = '0;
    v.last = 1'b1;
    v.err = code;
    vertex_q.push_back(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  // counterclockwise by phase in 2^-24 turn
  function automatic void rotate_vec(inout longint x, inout longint y, input longint phase);
    longint atan_tab[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                             20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    longint z, dx, dy, t;
    int q;
    phase = phase & (TURN - 1);
    q = int'(phase >> 22);
    z = phase & ((64'd1 << 22) - 1);
    if (z != 0) begin
      x = (x * 39797) >>> 16;
      y = (y * 39797) >>> 16;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
    end
    while (q != 0) begin
      t = x; x = -y; y = t; q--;
    end
  endfunction

  function automatic void ring_vertices(longint rx, longint ry, int steps, bit star);
    longint x, y, a;
    for (int i = 0; i < steps; i++) begin
      x = rx;
      y = ry;
      a = (longint'(i) * TURN + steps / 2) / steps;
      if (star && i[0]) begin
        x = x >>> 1;
        y = y >>> 1;
      end
      rotate_vec(x, y, (TURN - a) & (TURN - 1));
      add_vertex(x, y);
    end
    if (close_outline) add_vertex(rx, ry);
  endfunction

  function automatic void predict_outline(shape_req_t r);
    longint sz, ht, th, cnt, dx, dy, l2, len, rx, ry, hw, hh, s4, h, y2;
    int n0, tips;
    sz = r.size; ht = r.height; th = r.thick; cnt = r.count;
    dx = r.dir_x; dy = r.dir_y;
    n0 = vertex_q.size();
    case (r.op)
      OP_CIRCLE: begin
        if (sz <= 0) begin add_error(ERR_RADIUS); return; end
        if (cnt > 0) ring_vertices(sz << 8, 0, int'(cnt > MAX_COUNT ? MAX_COUNT : cnt), 0);
        else if (close_outline) add_vertex(sz << 8, 0);
      end
      OP_RECT: begin
        hw = sz * 128; hh = ht * 128;
        add_vertex(-hw, -hh); add_vertex(-hw, hh);
        add_vertex(hw, hh);   add_vertex(hw, -hh);
        if (close_outline) add_vertex(-hw, -hh);
      end
      OP_TRI, OP_STAR: begin
        l2 = dx * dx + dy * dy;
        if (l2 == 0) begin add_error(ERR_DIR); return; end
        if (sz <= 0) begin add_error(ERR_RADIUS); return; end
        tips = 0;
        if (r.op == OP_STAR) begin
          if (cnt < 4) begin add_error(ERR_TIPS); return; end
          tips = int'(cnt > MAX_COUNT / 2 ? MAX_COUNT / 2 : cnt);
        end
        len = int_sqrt(l2 << 16);
        rx = round_div(dx * sz * 65536, len);
        ry = round_div(dy * sz * 65536, len);
        if (r.op == OP_TRI) ring_vertices(rx, ry, 3, 0);
        else ring_vertices(rx, ry, tips * 2, 1);
      end
      OP_CROSS: begin
        if (th == 0 || th >= 16384) begin add_error(ERR_THICK); return; end
        hw = sz * 128; s4 = (sz * th) >>> 7;
        add_vertex(-hw, -s4); add_vertex(-hw, s4);  add_vertex(-s4, s4);
        add_vertex(-s4, hw);  add_vertex(s4, hw);   add_vertex(s4, s4);
        add_vertex(hw, s4);   add_vertex(hw, -s4);  add_vertex(s4, -s4);
        add_vertex(s4, -hw);  add_vertex(-s4, -hw); add_vertex(-s4, -s4);
        if (close_outline) add_vertex(-hw, -s4);
      end
      OP_ARROW: begin
        hw = sz * 128; s4 = (sz * th) >>> 7;
        h = (s4 * 113512 + 32768) >>> 16;
        y2 = (s4 * 40503 + 32768) >>> 16;
        add_vertex(-hw, -y2);   add_vertex(-hw, y2);    add_vertex(hw - h, y2);
        add_vertex(hw - h, s4); add_vertex(hw, 0);      add_vertex(hw - h, -s4);
        add_vertex(hw - h, -y2);
        if (close_outline) add_vertex(-hw, -y2);
      end
      default: return;
    endcase
    if (vertex_q.size() > n0) vertex_q[vertex_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_shape(shape_req_t r, bit typed, logic [2:0] err);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      shp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    shp.valid     <= 1'b1;
    shp.operation <= r.op;
    shp.size      <= r.size;
    shp.height    <= r.height;
    shp.thickness <= r.thick;
    shp.count     <= r.count;
    shp.dir_x     <= r.dir_x;
    shp.dir_y     <= r.dir_y;
    do @(posedge clk); while (!shp.ready);
    shapes_sent++;
    if (typed) add_error(err);
    else predict_outline(r);
  endtask

  // leaves valid high so writes can follow back to back; the caller drops it
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_OFFSET_X: offset_x = longint'(signed'(data));
      CFG_OFFSET_Y: offset_y = longint'(signed'(data));
      CFG_REPEAT:   close_outline = data[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    shp.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic shape_req_t random_shape();
    shape_req_t r;
    int pick;
    pick = $urandom_range(0, 39);
    r.op = pick < 2 ? 3'($urandom_range(6, 7)) : 3'(pick % 6);
    r.size = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(1, 6000));
    r.height = 16'($urandom);
    r.thick = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 16383));
    r.count = $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 12));
    r.dir_x = 16'($urandom);
    r.dir_y = 16'($urandom);
    case ($urandom_range(0, 9))
      0: begin r.dir_x = '0; r.dir_y = '0; end
      1: r.dir_x = '0;
      2: r.dir_y = '0;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- result sink and checker ----------------
  initial begin
    int stall;
    vtx.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        vtx.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      vtx.ready <= 1'b1;
      do @(posedge clk); while (!vtx.valid);
    end
  end

  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst_n && vtx.valid && vtx.ready) begin
      vertices_seen++;
      if (vertex_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected vertex x=%0d y=%0d last=%0d err=%0d", $time,
                 vtx.vertex_x, vtx.vertex_y, vtx.last, vtx.error);
      end else begin
        exp_v = vertex_q.pop_front();
        if (vtx.vertex_x !== exp_v.x || vtx.vertex_y !== exp_v.y ||
            vtx.last !== exp_v.last || vtx.error !== exp_v.err) begin
          mismatches++;
          $display("%0t: expected x=%0d y=%0d last=%0d err=%0d, got x=%0d y=%0d last=%0d err=%0d",
                   $time, exp_v.x, exp_v.y, exp_v.last, exp_v.err,
                   vtx.vertex_x, vtx.vertex_y, vtx.last, vtx.error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((shp.valid && shp.ready) || (vtx.valid && vtx.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress, %0d vertices outstanding", $time, vertex_q.size());
      $display("tb_shape_vertex_generator failed");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  directed_row_t directed[] = '{
    '{'{OP_CIRCLE, 16'sd0, 16'sd0, 16'd0, 6'd5, 16'sd0, 16'sd0}, 1, ERR_RADIUS},
    '{'{OP_CIRCLE, -16'sd1, 16'sd0, 16'd0, 6'd5, 16'sd0, 16'sd0}, 1, ERR_RADIUS},
    '{'{OP_TRI, 16'sd256, 16'sd0, 16'd0, 6'd0, 16'sd0, 16'sd0}, 1, ERR_DIR},
    '{'{OP_STAR, -16'sd5, 16'sd0, 16'd0, 6'd5, 16'sd0, 16'sd0}, 1, ERR_DIR},
    '{'{OP_STAR, -16'sd5, 16'sd0, 16'd0, 6'd5, 16'sd1, 16'sd0}, 1, ERR_RADIUS},
    '{'{OP_STAR, 16'sd512, 16'sd0, 16'd0, 6'd3, 16'sd1, 16'sd1}, 1, ERR_TIPS},
    '{'{OP_CROSS, 16'sd512, 16'sd0, 16'd0, 6'd0, 16'sd0, 16'sd0}, 1, ERR_THICK},
    '{'{OP_CROSS, 16'sd512, 16'sd0, 16'd16384, 6'd0, 16'sd0, 16'sd0}, 1, ERR_THICK},
    '{'{OP_CROSS, 16'sd512, 16'sd0, 16'hffff, 6'd0, 16'sd0, 16'sd0}, 1, ERR_THICK},
    '{'{3'd6, 16'sd512, 16'sd0, 16'd0, 6'd4, 16'sd1, 16'sd0}, 0, ERR_NONE},
    '{'{3'd7, 16'sd512, 16'sd0, 16'd0, 6'd4, 16'sd1, 16'sd0}, 0, ERR_NONE},
    '{'{OP_CIRCLE, 16'sd256, 16'sd0, 16'd0, 6'd0, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_CIRCLE, 16'sh7fff, 16'sd0, 16'd0, 6'd63, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_CIRCLE, 16'sd1, 16'sd0, 16'd0, 6'd1, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_RECT, 16'sh7fff, 16'sh8000, 16'd0, 6'd0, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_RECT, -16'sd1, 16'sd1, 16'd0, 6'd0, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_TRI, 16'sh7fff, 16'sd0, 16'd0, 6'd0, 16'sh7fff, 16'sh8000}, 0, ERR_NONE},
    '{'{OP_TRI, 16'sd1, 16'sd0, 16'd0, 6'd0, 16'sd0, 16'sd1}, 0, ERR_NONE},
    '{'{OP_STAR, 16'sd100, 16'sd0, 16'd0, 6'd63, -16'sd1, 16'sd0}, 0, ERR_NONE},
    '{'{OP_STAR, 16'sd2000, 16'sd0, 16'd0, 6'd4, 16'sd300, -16'sd700}, 0, ERR_NONE},
    '{'{OP_CROSS, 16'sh8000, 16'sd0, 16'd16383, 6'd0, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_CROSS, 16'sh7fff, 16'sd0, 16'd1, 6'd0, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_ARROW, 16'sh7fff, 16'sd0, 16'hffff, 6'd0, 16'sd0, 16'sd0}, 0, ERR_NONE},
    '{'{OP_ARROW, 16'sh8000, 16'sd0, 16'd0, 6'd0, 16'sd5, 16'sd5}, 0, ERR_NONE}
  };

  initial begin
    logic [15:0] ox[4] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0000};
    logic [15:0] oy[4] = '{16'h0000, 16'h8000, 16'h7fff, 16'h0000};
    logic        rp[4] = '{1'b1, 1'b0, 1'b1, 1'b0};
    cfg.valid <= 1'b0; cfg.index <= '0; cfg.data <= '0;
    shp.valid <= 1'b0; shp.operation <= '0; shp.size <= '0; shp.height <= '0;
    shp.thickness <= '0; shp.count <= '0; shp.dir_x <= '0; shp.dir_y <= '0;
    offset_x = 0; offset_y = 0; close_outline = 1'b1;
    mismatches = 0; shapes_sent = 0; vertices_seen = 0; idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows run with reset register values
    foreach (directed[i]) send_shape(directed[i].req, directed[i].typed, directed[i].err);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        ox[3] = 16'($urandom);
        oy[3] = 16'($urandom);
      end
      write_reg(CFG_OFFSET_X, ox[ph]);
      write_reg(CFG_OFFSET_Y, oy[ph]);
      write_reg(CFG_REPEAT, {15'd0, rp[ph]});
      cfg.valid <= 1'b0;
      for (int n = 0; n < 100; n++) send_shape(random_shape(), 0, ERR_NONE);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("%0d shape requests over 4 offset/close settings, %0d vertices checked",
             shapes_sent, vertices_seen);
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("tb_shape_vertex_generator passed");
    end else begin
      $display("%0d mismatches, %0d vertices missing", mismatches, vertex_q.size());
      $display("tb_shape_vertex_generator failed");
    end
    $finish;
  end

endmodule
